// File: hdl/bpra_pkg.sv
// shared types and operation codes for the page run allocator
package bpra_pkg;
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_MARK    = 2'd2;
  localparam logic [1:0] OP_RESERVE = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [14:0] first_page;
    logic [15:0] request_count;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic [14:0] base_page;
    logic [15:0] granted_count;
  } rsp_t;
endpackage

// File: hdl/bpra_if.sv
// valid/ready channel interfaces for requests and responses
interface bpra_req_if import bpra_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bpra_rsp_if import bpra_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/bitmap_page_run_allocator.sv
// page bitmap allocator top level with byte-serial sequencer
//  channel  dir  beat
//  req      in   operation, first_page, request_count
//  rsp      out  granted, base_page, granted_count
// memory: one byte read or written per cycle, read data registered
// after reset a clearing pass zeroes every map byte before the first request
// allocate: each byte scanned or taken is read (S_READ), then evaluated and written back (S_EVAL)
// free, mark and reserve: each byte touched goes through the same S_READ and S_EVAL steps
// req ready only in idle; a stalled response holds the block in its done state
module bitmap_page_run_allocator import bpra_pkg::*; #(
  parameter int MAP_BYTES = 4096
) (
  input logic clk,
  input logic rst,
  bpra_req_if.sink req,
  bpra_rsp_if.source rsp
);
  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int PW = AW + 3;
  localparam logic [PW:0] TOTAL = (PW+1)'(MAP_BYTES) << 3;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [7:0] mem [MAP_BYTES];
  logic [7:0] rdata;
  logic [2:0] state;
  logic [AW:0] clr;
  logic [AW-1:0] hint;
  logic [1:0] op;
  logic [PW:0] page;
  logic [16:0] left;
  logic found;
  logic [PW:0] base;
  logic [16:0] got;
  logic [7:0] wdata;
  logic we;
  logic [AW-1:0] waddr;
  logic [7:0] cur;
  logic [3:0] n;
  logic [3:0] adv;
  logic stop;
  logic [PW:0] page_next;
  logic [16:0] left_next;
  logic [16:0] got_next;
  logic found_next;
  logic [PW:0] base_next;
  logic done_next;
  logic [AW-1:0] hint_next;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[page[PW-1:3]];
  end

  // walk the pages of one byte, at most eight narrow steps
  always_comb begin
    cur = rdata;
    n = 4'd0;
    adv = 4'd0;
    found_next = found;
    base_next = base;
    hint_next = hint;
    stop = (page >= TOTAL);
    for (int i = 0; i < 8; i++) begin
      if (!stop && 3'(i) >= page[2:0]) begin
        if (17'(n) == left) begin
          stop = 1'b1;
        end else if (op == OP_ALLOC) begin
          if (cur[i]) begin
            if (!found_next) begin
              found_next = 1'b1;
              base_next = {page[PW:3], 3'(i)};
            end
            cur[i] = 1'b0;
            n = n + 4'd1;
            adv = adv + 4'd1;
          end else if (found_next) begin
            stop = 1'b1;
          end else begin
            adv = adv + 4'd1;
          end
        end else begin
          cur[i] = (op != OP_RESERVE);
          if (op == OP_FREE) hint_next = page[PW-1:3];
          n = n + 4'd1;
          adv = adv + 4'd1;
        end
      end
    end
    page_next = page + (PW+1)'(adv);
    left_next = left - 17'(n);
    got_next = got + 17'(n);
    done_next = stop || page_next >= TOTAL || left_next == 17'd0;
  end

  always_comb begin
    we = 1'b0;
    waddr = page[PW-1:3];
    wdata = cur;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr[AW-1:0];
      wdata = 8'd0;
    end else if (state == S_EVAL) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      hint <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(MAP_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            op <= req.payload.operation;
            left <= {1'b0, req.payload.request_count};
            got <= '0;
            found <= 1'b0;
            base <= '0;
            if (req.payload.operation == OP_ALLOC) begin
              page <= {1'b0, hint, 3'd0};
            end else begin
              page <= (PW+1)'(req.payload.first_page);
            end
            if (req.payload.request_count == 16'd0) begin
              state <= S_DONE;
            end else if (req.payload.operation != OP_ALLOC &&
                         (PW+1)'(req.payload.first_page) >= TOTAL) begin
              state <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          page <= page_next;
          left <= left_next;
          got <= got_next;
          found <= found_next;
          base <= base_next;
          hint <= hint_next;
          state <= done_next ? S_DONE : S_READ;
        end
        S_DONE: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.payload.granted = (op == OP_ALLOC) ? found : 1'b1;
    rsp.payload.base_page = (op == OP_ALLOC && found) ? base[14:0] : 15'd0;
    rsp.payload.granted_count = (op == OP_ALLOC) ? got[15:0] : 16'd0;
  end
endmodule
